FILE: hw/rtl/imu_dead_reckoning_integrator_unit_assert.svh
// Assertion macros used by the integrator top level.
`ifndef IMU_DEAD_RECKONING_INTEGRATOR_UNIT_ASSERT_SVH
`define IMU_DEAD_RECKONING_INTEGRATOR_UNIT_ASSERT_SVH
// Same-cycle implication, sampled on the rising clock and idle during reset.
`define IMUDR_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("integrator assertion failed");
// Next-cycle implication, sampled on the rising clock and idle during reset.
`define IMUDR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("integrator assertion failed");
`endif

FILE: hw/rtl/imudr_pkg.sv
// Package of types, constants and arithmetic helpers for the integrator.
`default_nettype none
package imudr_pkg;
   localparam int TIME_WIDTH_DEF   = 48;
   localparam int SAMPLE_WIDTH_DEF = 32;
   localparam int TIME_FRAC        = 20;
   localparam int SAMPLE_FRAC      = 16;
   localparam int STATE_FRAC       = 32;
   localparam int SHIFT_VEL        = TIME_FRAC;
   localparam int SHIFT_DV         = SAMPLE_FRAC + TIME_FRAC + 1 - STATE_FRAC;
   localparam int SHIFT_POS        = SAMPLE_FRAC + 2 * TIME_FRAC + 2 - STATE_FRAC;
   localparam int NUM_STEPS        = 16;
   localparam int STEP_W           = $clog2(NUM_STEPS);
   localparam int ACC_W            = 192;
   localparam int CSR_INDEX_W      = 3;
   localparam int NUM_AXES         = 3;

   localparam logic signed [31:0] GRAVITY_Z_RESET = 32'sd642690;
   localparam logic [63:0]        MAX_GAP_RESET   = 64'd1048576;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRAVITY_X, CSR_GRAVITY_Y, CSR_GRAVITY_Z, CSR_MAX_GAP,
      CSR_BIAS_X, CSR_BIAS_Y, CSR_BIAS_Z
   } imudr_csr_type;

   typedef enum logic [1:0] {
      KIND_LATCH, KIND_RESTART, KIND_INTEG
   } imudr_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_RUN, ST_DRAIN, ST_FIN_A, ST_FIN_B, ST_DONE
   } imudr_state_type;

   typedef struct packed {
      logic              start;
      imudr_kind_type    kind;
      logic              mul_en;
      logic [STEP_W-1:0] step;
      logic              fin_a;
      logic              fin_b;
   } imudr_lane_ctrl_type;

   typedef struct packed {
      logic signed [63:0] pos;
      logic signed [63:0] vel;
      logic signed [31:0] omega;
   } imudr_axis_type;

   typedef struct packed {
      imudr_axis_type [NUM_AXES-1:0] axis;
      logic [31:0]                   rejected;
      logic [31:0]                   restarts;
   } imudr_result_type;

   // Magnitude shifted right (toward zero), signed and clamped to 64 bits.
   function automatic logic signed [63:0] sat_shrink(input logic neg,
                                                     input logic [ACC_W-1:0] mag,
                                                     input int unsigned sh);
      logic [ACC_W-1:0] shifted;
      logic             over;
      logic [63:0]      low;
      shifted = mag >> sh;
      over    = |shifted[ACC_W-1:64];
      low     = shifted[63:0];
      if (neg) begin
         if (over || low[63]) return {1'b1, 63'd0};
         return -$signed(low);
      end
      if (over || low[63]) return {1'b0, {63{1'b1}}};
      return $signed(low);
   endfunction

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (!a[63] && !b[63] && s[63]) return {1'b0, {63{1'b1}}};
      if (a[63] && b[63] && !s[63]) return {1'b1, 63'd0};
      return s;
   endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/imudr_if.sv
// Handshake interfaces for the sample and result channels.
`default_nettype none
interface imudr_req_if #(parameter int TIME_WIDTH = 48);
   logic                  valid;
   logic                  ready;
   logic [TIME_WIDTH-1:0] sample_time;
   logic signed [31:0]    acc_x, acc_y, acc_z;
   logic signed [31:0]    rate_x, rate_y, rate_z;
   modport source(output valid, sample_time, acc_x, acc_y, acc_z, rate_x, rate_y, rate_z,
                  input ready);
   modport sink(input valid, sample_time, acc_x, acc_y, acc_z, rate_x, rate_y, rate_z,
                output ready);
endinterface

interface imudr_rsp_if #(parameter int TIME_WIDTH = 48);
   logic                  valid;
   logic                  ready;
   logic signed [63:0]    pos_x, pos_y, pos_z;
   logic signed [63:0]    vel_x, vel_y, vel_z;
   logic signed [31:0]    omega_x, omega_y, omega_z;
   logic [31:0]           rejected_count;
   logic [31:0]           restart_count;
   logic [TIME_WIDTH-1:0] latched_time;
   modport source(output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, omega_x, omega_y,
                  omega_z, rejected_count, restart_count, latched_time, input ready);
   modport sink(input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, omega_x, omega_y,
                omega_z, rejected_count, restart_count, latched_time, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/imudr_lane.sv
// One axis lane: sample correction, shared 32x32 multiplier sequence and state update.
`default_nettype none
module imudr_lane
   import imudr_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire imudr_lane_ctrl_type ctrl,
   input  wire logic signed [31:0]  acc_in,
   input  wire logic signed [31:0]  rate_in,
   input  wire logic signed [31:0]  grav,
   input  wire logic signed [31:0]  bias,
   input  wire logic [63:0]         dt,
   output imudr_axis_type           res
);
   localparam logic signed [32:0] SAT_HI = 33'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [32:0] SAT_LO = -SAT_HI - 33'sd1;

   logic signed [63:0]             pos_ff, vel_ff, aterm_ff;
   logic signed [SAMPLE_WIDTH-1:0] prev_acc_ff, prev_rate_ff;
   logic [32:0]                    sum_mag_ff;
   logic                           sum_neg_ff;
   logic [63:0]                    prod_ff;
   logic                           madd_en_ff;
   logic [STEP_W-1:0]              madd_step_ff;
   logic [127:0]                   p1_ff, p2_ff;
   logic [ACC_W-1:0]               p3_ff;

   logic signed [32:0]             acc_diff, rate_diff;
   logic signed [SAMPLE_WIDTH-1:0] acc_cor, rate_cor;
   logic signed [SAMPLE_WIDTH:0]   sum_w;
   logic signed [32:0]             sum33;
   logic [63:0]                    vmag;
   logic [31:0]                    op_a, op_b;
   logic [2:0]                     sh;
   logic [ACC_W-1:0]               addend;
   logic signed [63:0]             vterm, dv, aterm;

   always_comb begin
      acc_diff  = 33'(acc_in) - 33'(grav);
      rate_diff = 33'(rate_in) - 33'(bias);
      if (acc_diff > SAT_HI) acc_cor = SAMPLE_WIDTH'(SAT_HI);
      else if (acc_diff < SAT_LO) acc_cor = SAMPLE_WIDTH'(SAT_LO);
      else acc_cor = SAMPLE_WIDTH'(acc_diff);
      if (rate_diff > SAT_HI) rate_cor = SAMPLE_WIDTH'(SAT_HI);
      else if (rate_diff < SAT_LO) rate_cor = SAMPLE_WIDTH'(SAT_LO);
      else rate_cor = SAMPLE_WIDTH'(rate_diff);
      sum_w = (SAMPLE_WIDTH+1)'(prev_acc_ff) + (SAMPLE_WIDTH+1)'(acc_cor);
      sum33 = 33'(sum_w);
   end

   // Operand choice: steps 0-3 sum*dt, 4-7 |vel|*dt, 8-15 (sum*dt)*dt.
   always_comb begin
      vmag = vel_ff[63] ? 64'(-vel_ff) : 64'(vel_ff);
      op_b = dt[{ctrl.step[0], 5'd0} +: 32];
      if (ctrl.step[3]) begin
         op_a = p2_ff[{ctrl.step[2:1], 5'd0} +: 32];
      end else if (ctrl.step[2]) begin
         op_a = vmag[{ctrl.step[1], 5'd0} +: 32];
      end else begin
         op_a = ctrl.step[1] ? {31'd0, sum_mag_ff[32]} : sum_mag_ff[31:0];
      end
   end

   always_comb begin
      if (madd_step_ff[3]) sh = 3'({1'b0, madd_step_ff[2:1]}) + 3'(madd_step_ff[0]);
      else sh = 3'(madd_step_ff[1]) + 3'(madd_step_ff[0]);
      addend = ACC_W'(prod_ff) << {sh, 5'd0};
      vterm  = sat_shrink(vel_ff[63], ACC_W'(p1_ff), SHIFT_VEL);
      dv     = sat_shrink(sum_neg_ff, ACC_W'(p2_ff), SHIFT_DV);
      aterm  = sat_shrink(sum_neg_ff, p3_ff, SHIFT_POS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         vel_ff       <= '0;
         prev_acc_ff  <= '0;
         prev_rate_ff <= '0;
         madd_en_ff   <= 1'b0;
      end else begin
         madd_en_ff <= ctrl.mul_en;
         if (ctrl.start) begin
            prev_acc_ff  <= acc_cor;
            prev_rate_ff <= rate_cor;
            if (ctrl.kind == KIND_RESTART) begin
               pos_ff <= '0;
               vel_ff <= '0;
            end
         end
         if (ctrl.fin_a) begin
            pos_ff <= sat_add(pos_ff, vterm);
            vel_ff <= sat_add(vel_ff, dv);
         end
         if (ctrl.fin_b) begin
            pos_ff <= sat_add(pos_ff, aterm_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= 64'(op_a) * 64'(op_b);
      madd_step_ff <= ctrl.step;
      if (ctrl.fin_a) aterm_ff <= aterm;
      if (ctrl.start) begin
         sum_neg_ff <= sum33[32];
         sum_mag_ff <= sum33[32] ? 33'(-sum33) : 33'(sum33);
         p1_ff      <= '0;
         p2_ff      <= '0;
         p3_ff      <= '0;
      end else if (madd_en_ff) begin
         if (madd_step_ff[3]) p3_ff <= p3_ff + addend;
         else if (madd_step_ff[2]) p1_ff <= p1_ff + addend[127:0];
         else p2_ff <= p2_ff + addend[127:0];
      end
   end

   assign res.pos   = pos_ff;
   assign res.vel   = vel_ff;
   assign res.omega = 32'(prev_rate_ff);
endmodule
`default_nettype wire

FILE: hw/rtl/imudr_merge.sv
// Output stage: gathers the three lanes and the tallies into one result register.
`default_nettype none
module imudr_merge
   import imudr_pkg::*;
#(
   parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire imudr_result_type      result,
   input  wire logic [TIME_WIDTH-1:0] stamp,
   output logic                       can_load,
   imudr_rsp_if.source                rsp_ch
);
   logic                  valid_ff;
   imudr_result_type      data_ff;
   logic [TIME_WIDTH-1:0] stamp_ff;

   assign can_load = !valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff  <= result;
         stamp_ff <= stamp;
      end
   end

   assign rsp_ch.valid          = valid_ff;
   assign rsp_ch.pos_x          = data_ff.axis[0].pos;
   assign rsp_ch.pos_y          = data_ff.axis[1].pos;
   assign rsp_ch.pos_z          = data_ff.axis[2].pos;
   assign rsp_ch.vel_x          = data_ff.axis[0].vel;
   assign rsp_ch.vel_y          = data_ff.axis[1].vel;
   assign rsp_ch.vel_z          = data_ff.axis[2].vel;
   assign rsp_ch.omega_x        = data_ff.axis[0].omega;
   assign rsp_ch.omega_y        = data_ff.axis[1].omega;
   assign rsp_ch.omega_z        = data_ff.axis[2].omega;
   assign rsp_ch.rejected_count = data_ff.rejected;
   assign rsp_ch.restart_count  = data_ff.restarts;
   assign rsp_ch.latched_time   = stamp_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/imu_dead_reckoning_integrator_unit.sv
// Top level of the fixed-point IMU dead-reckoning integrator.
//
//  Port      Direction  Contents
//  req_ch    in         one stamped IMU sample word: time, acceleration, rate
//  rsp_ch    out        one state word per sample: position, velocity, rate, tallies
//  csr_*     in         register writes: gravity, largest gap, rate bias
//
// An integrating sample reaches the result register through sixteen 32x32 partial
// products per lane on one multiplier each, a drain state, the saturating adds of FIN_A
// and FIN_B and a load. Samples that do not integrate (first, backwards, oversized gap)
// go straight from acceptance to the load; a new sample is accepted only in idle.
// Synchronous reset clears sequencer, positions, velocities and tallies, loads CSR defaults.
// A stalled result word holds in the output register while the next sample is taken.
`default_nettype none
module imu_dead_reckoning_integrator_unit
   import imudr_pkg::*;
#(
   parameter int TIME_WIDTH   = TIME_WIDTH_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   imudr_req_if.sink                   req_ch,
   imudr_rsp_if.source                 rsp_ch,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [TIME_WIDTH-1:0]  csr_wdata
);
`include "imu_dead_reckoning_integrator_unit_assert.svh"

   // Configuration registers.
   logic signed [31:0]    grav_ff [NUM_AXES];
   logic signed [31:0]    bias_ff [NUM_AXES];
   logic [TIME_WIDTH-1:0] max_gap_ff;

   // Sequencer and sample-level state.
   imudr_state_type       state_ff, state_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [TIME_WIDTH-1:0] prev_time_ff, dt_ff;
   logic                  primed_ff;
   logic [31:0]           reject_ff, restart_ff;

   logic                  accept, backwards, too_far, can_load, load;
   logic [TIME_WIDTH-1:0] dt_now;
   imudr_kind_type        kind;
   imudr_lane_ctrl_type   lane_ctrl;
   imudr_result_type      result;
   logic signed [31:0]    acc_in [NUM_AXES];
   logic signed [31:0]    rate_in [NUM_AXES];

   assign accept = req_ch.valid && req_ch.ready;

   // The sample is classified at acceptance from the stamp alone.
   always_comb begin
      backwards = req_ch.sample_time < prev_time_ff;
      dt_now    = req_ch.sample_time - prev_time_ff;
      too_far   = dt_now > max_gap_ff;
      priority if (!primed_ff) kind = KIND_LATCH;
      else if (backwards) kind = KIND_RESTART;
      else if (too_far) kind = KIND_LATCH;
      else kind = KIND_INTEG;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff[0] <= '0;
         grav_ff[1] <= '0;
         grav_ff[2] <= GRAVITY_Z_RESET;
         bias_ff[0] <= '0;
         bias_ff[1] <= '0;
         bias_ff[2] <= '0;
         max_gap_ff <= TIME_WIDTH'(MAX_GAP_RESET);
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRAVITY_X: grav_ff[0] <= csr_wdata[31:0];
            CSR_GRAVITY_Y: grav_ff[1] <= csr_wdata[31:0];
            CSR_GRAVITY_Z: grav_ff[2] <= csr_wdata[31:0];
            CSR_MAX_GAP:   max_gap_ff <= csr_wdata;
            CSR_BIAS_X:    bias_ff[0] <= csr_wdata[31:0];
            CSR_BIAS_Y:    bias_ff[1] <= csr_wdata[31:0];
            CSR_BIAS_Z:    bias_ff[2] <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // Time stamp, priming and the two saturating tallies.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff <= '0;
         primed_ff    <= 1'b0;
         reject_ff    <= '0;
         restart_ff   <= '0;
      end else if (accept) begin
         prev_time_ff <= req_ch.sample_time;
         primed_ff    <= 1'b1;
         if (primed_ff && backwards) begin
            reject_ff <= '0;
            if (restart_ff != '1) restart_ff <= restart_ff + 32'd1;
         end else if (primed_ff && too_far) begin
            if (reject_ff != '1) reject_ff <= reject_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) dt_ff <= dt_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (accept) state_in = (kind == KIND_INTEG) ? ST_RUN : ST_DONE;
         end
         ST_RUN: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(NUM_STEPS - 1)) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_FIN_A;
         ST_FIN_A: state_in = ST_FIN_B;
         ST_FIN_B: state_in = ST_DONE;
         ST_DONE: begin
            load = can_load;
            if (can_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ch.ready = (state_ff == ST_IDLE);

   always_comb begin
      lane_ctrl.start  = accept;
      lane_ctrl.kind   = kind;
      lane_ctrl.mul_en = (state_ff == ST_RUN);
      lane_ctrl.step   = step_ff;
      lane_ctrl.fin_a  = (state_ff == ST_FIN_A);
      lane_ctrl.fin_b  = (state_ff == ST_FIN_B);
   end

   assign acc_in[0]  = req_ch.acc_x;
   assign acc_in[1]  = req_ch.acc_y;
   assign acc_in[2]  = req_ch.acc_z;
   assign rate_in[0] = req_ch.rate_x;
   assign rate_in[1] = req_ch.rate_y;
   assign rate_in[2] = req_ch.rate_z;

   // One lane per axis, all driven by the same sequencer.
   for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
      imudr_lane #(
         .SAMPLE_WIDTH(SAMPLE_WIDTH)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (lane_ctrl),
         .acc_in  (acc_in[g]),
         .rate_in (rate_in[g]),
         .grav    (grav_ff[g]),
         .bias    (bias_ff[g]),
         .dt      (64'(dt_ff)),
         .res     (result.axis[g])
      );
   end

   assign result.rejected = reject_ff;
   assign result.restarts = restart_ff;

   imudr_merge #(
      .TIME_WIDTH(TIME_WIDTH)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .result   (result),
      .stamp    (prev_time_ff),
      .can_load (can_load),
      .rsp_ch   (rsp_ch)
   );

   // A result word only appears after the sequencer has reached its final state.
   `IMUDR_ASSERT_IMPL(a_rsp_from_done, $rose(rsp_ch.valid), $past(state_ff) == ST_DONE)
   // An accepted sample either starts the multiplier sequence or finishes at once.
   `IMUDR_ASSERT_NEXT(a_accept_moves, accept, state_ff == ST_RUN || state_ff == ST_DONE)
   // A backwards stamp always clears the rejection tally.
   `IMUDR_ASSERT_NEXT(a_restart_clears, accept && primed_ff && backwards, reject_ff == '0)
endmodule
`default_nettype wire
